// File: rtl/locq_pkg.sv
// Package for the latency-ordered completion queue: opcodes, result kinds,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package locq_pkg;

  localparam int READY_DEPTH_DEF  = 16;
  localparam int FLIGHT_DEPTH_DEF = 16;
  localparam int CYCLE_W          = 48;
  localparam int RESULT_LIMIT     = 16;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_TICK    = 2'd1,
    OP_DISCARD = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_DONE      = 2'd0,
    KIND_DISCARDED = 2'd1,
    KIND_NOT_FOUND = 2'd2,
    KIND_FULL      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_WIDTH = 2'd0,
    REG_LIMIT = 2'd1,
    REG_ZERO  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_INSERT,
    ST_DRAIN,
    ST_SEARCH_F,
    ST_SEARCH_R,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch;       // capture the input transaction
    logic push;        // append to ready FIFO
    logic ins_step;    // one step of sorted insertion (shift one entry up)
    logic ins_place;   // write the new entry at the insertion point
    logic ins_load;    // pop ready head into insertion holding register
    logic emit_head;   // emit and remove flight head
    logic f_step;      // advance flight search / removal shift
    logic r_step;      // advance ready search / removal shift
    logic scan_clr;    // reset scan index
    logic tick_done;   // advance cycle counter
    logic out_valid;   // drive a result
    logic [1:0] out_kind;
    logic out_last;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic ready_full;
    logic ready_empty;
    logic flight_room;
    logic width_left;
    logic ins_done;     // insertion point reached
    logic head_due;     // flight head exists and is due
    logic emit_left;    // fewer than RESULT_LIMIT emitted
    logic f_match;      // flight entry at scan index matches
    logic f_end;        // flight scan finished without match
    logic r_match;
    logic r_end;
    logic shift_done;   // removal shift reached end
    logic removing;     // removal shift in progress
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/latency_ordered_completion_queue.sv
// Top level of the latency-ordered completion queue: configuration registers,
// controller and datapath. Depends on locq_pkg, locq_ctrl and locq_datapath.
// A push appends to the ready FIFO; a tick starts jobs by sorted insertion and
// then emits completed jobs; a discard scans for the id and shifts to close
// the gap. One transaction is worked at a time.
// Results carry no backpressure. Synchronous reset empties both stores and
// clears the cycle counter; store contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module latency_ordered_completion_queue #(
  parameter int READY_DEPTH  = locq_pkg::READY_DEPTH_DEF,
  parameter int FLIGHT_DEPTH = locq_pkg::FLIGHT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_job_id,
  input  wire logic [63:0] in_job_value,
  input  wire logic [9:0]  in_job_latency,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_done_id,
  output logic [63:0]      out_done_value,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import locq_pkg::*;

  logic [4:0] width_r, limit_r;
  logic       zero_r;
  cmd_t       cmd;
  stat_t      stat;
  logic [15:0] dp_id;
  logic [63:0] dp_val;
  logic [15:0] id_hold_r;

  // Configuration writes land directly; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 5'd1;
      limit_r <= 5'd16;
      zero_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH: width_r <= cfg_data;
        REG_LIMIT: limit_r <= cfg_data;
        REG_ZERO:  zero_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Non-completion results report the id of the transaction itself.
  always_ff @(posedge clk) begin
    if (start && !busy) id_hold_r <= in_job_id;
  end

  locq_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_opcode, .stat, .cmd, .busy
  );

  locq_datapath #(.READY_DEPTH(READY_DEPTH), .FLIGHT_DEPTH(FLIGHT_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_job_id, .in_job_value, .in_job_latency,
    .cfg_width(width_r), .cfg_limit(limit_r), .cfg_zero(zero_r),
    .out_done_id(dp_id), .out_done_value(dp_val)
  );

  assign out_valid      = cmd.out_valid;
  assign out_kind       = cmd.out_kind;
  assign out_last       = cmd.out_last;
  assign out_done_id    = (cmd.out_kind == KIND_DONE) ? dp_id : id_hold_r;
  assign out_done_value = (cmd.out_kind == KIND_DONE) ? dp_val : 64'd0;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DONE) |-> out_last)
    else $error("status result without last flag");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DONE) |-> out_done_value == 64'd0)
    else $error("nonzero value on status result");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_valid)
    else $error("result after last");

endmodule
`default_nettype wire

// File: rtl/locq_datapath.sv
// Datapath of the completion queue: ready FIFO, sorted in-flight list, cycle
// counter and scan index. Depends on locq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module locq_datapath #(
  parameter int READY_DEPTH  = locq_pkg::READY_DEPTH_DEF,
  parameter int FLIGHT_DEPTH = locq_pkg::FLIGHT_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire locq_pkg::cmd_t    cmd,
  output locq_pkg::stat_t        stat,
  input  wire logic [15:0]       in_job_id,
  input  wire logic [63:0]       in_job_value,
  input  wire logic [9:0]        in_job_latency,
  input  wire logic [4:0]        cfg_width,
  input  wire logic [4:0]        cfg_limit,
  input  wire logic              cfg_zero,
  output logic [15:0]            out_done_id,
  output logic [63:0]            out_done_value
);
  import locq_pkg::*;

  localparam int RA = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int FA = (FLIGHT_DEPTH > 1) ? $clog2(FLIGHT_DEPTH) : 1;
  localparam int RC = $clog2(READY_DEPTH + 1);
  localparam int FC = $clog2(FLIGHT_DEPTH + 1);
  localparam int SW = (RC > FC) ? RC : FC;

  // Storage is held in flip-flops: a pop or emit shifts the whole store down at
  // once, while sorted insertion and removal move one entry per cycle.
  logic [15:0]        r_id_r   [READY_DEPTH];
  logic [63:0]        r_val_r  [READY_DEPTH];
  logic [9:0]         r_lat_r  [READY_DEPTH];
  logic [15:0]        f_id_r   [FLIGHT_DEPTH];
  logic [63:0]        f_val_r  [FLIGHT_DEPTH];
  logic [CYCLE_W-1:0] f_due_r  [FLIGHT_DEPTH];

  logic [RC-1:0]      r_cnt_r;
  logic [FC-1:0]      f_cnt_r;
  logic [CYCLE_W-1:0] cyc_r;
  logic [SW-1:0]      idx_r;      // scan / shift position
  logic [4:0]         started_r;
  logic [4:0]         emitted_r;
  logic               rem_r;      // removal shift active

  logic [15:0]        id_r;
  logic [63:0]        val_r;
  logic [9:0]         lat_r;
  logic [15:0]        h_id_r;
  logic [63:0]        h_val_r;
  logic [CYCLE_W-1:0] h_due_r;

  logic [4:0] limit;
  logic [FA-1:0] fi, fim1;
  logic [RA-1:0] ri;

  assign limit = (32'(cfg_limit) > FLIGHT_DEPTH) ? 5'(FLIGHT_DEPTH) : cfg_limit;
  assign fi    = idx_r[FA-1:0];
  assign fim1  = FA'(idx_r - SW'(1));
  assign ri    = idx_r[RA-1:0];

  always_comb begin
    stat.ready_full  = (32'(r_cnt_r) >= READY_DEPTH);
    stat.ready_empty = (r_cnt_r == '0);
    stat.flight_room = ({27'd0, f_cnt_r} < {27'd0, limit});
    stat.width_left  = (started_r < cfg_width);
    // Insertion walks down from the tail while the entry below is later.
    stat.ins_done    = (idx_r == '0) || !(f_due_r[fim1] > h_due_r);
    stat.head_due    = (f_cnt_r != '0) && (f_due_r[0] <= cyc_r);
    stat.emit_left   = (32'(emitted_r) < RESULT_LIMIT);
    stat.f_end       = (32'(idx_r) >= 32'(f_cnt_r));
    stat.f_match     = !stat.f_end && (f_id_r[fi] == id_r);
    stat.r_end       = (32'(idx_r) >= 32'(r_cnt_r));
    stat.r_match     = !stat.r_end && (r_id_r[ri] == id_r);
    stat.removing    = rem_r;
    stat.shift_done  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_cnt_r   <= '0;
      f_cnt_r   <= '0;
      cyc_r     <= '0;
      idx_r     <= '0;
      started_r <= '0;
      emitted_r <= '0;
      rem_r     <= 1'b0;
    end else begin
      if (cmd.latch) begin
        id_r      <= in_job_id;
        val_r     <= in_job_value;
        lat_r     <= cfg_zero ? 10'd0 : in_job_latency;
        started_r <= '0;
        emitted_r <= '0;
        rem_r     <= 1'b0;
        idx_r     <= '0;
      end
      if (cmd.push) begin
        r_id_r[r_cnt_r[RA-1:0]]  <= id_r;
        r_val_r[r_cnt_r[RA-1:0]] <= val_r;
        r_lat_r[r_cnt_r[RA-1:0]] <= lat_r;
        r_cnt_r <= r_cnt_r + RC'(1);
      end
      if (cmd.scan_clr) begin
        idx_r <= '0;
        rem_r <= 1'b0;
      end
      // Pop ready head into holding register; the FIFO shifts down at once.
      if (cmd.ins_load) begin
        h_id_r  <= r_id_r[0];
        h_val_r <= r_val_r[0];
        h_due_r <= cyc_r + CYCLE_W'(r_lat_r[0]);
        for (int k = 0; k + 1 < READY_DEPTH; k++) begin
          r_id_r[k]  <= r_id_r[k+1];
          r_val_r[k] <= r_val_r[k+1];
          r_lat_r[k] <= r_lat_r[k+1];
        end
        r_cnt_r   <= r_cnt_r - RC'(1);
        idx_r     <= SW'(f_cnt_r);
        started_r <= started_r + 5'd1;
      end
      if (cmd.ins_step) begin
        f_id_r[fi]  <= f_id_r[fim1];
        f_val_r[fi] <= f_val_r[fim1];
        f_due_r[fi] <= f_due_r[fim1];
        idx_r       <= idx_r - SW'(1);
      end
      if (cmd.ins_place) begin
        f_id_r[fi]  <= h_id_r;
        f_val_r[fi] <= h_val_r;
        f_due_r[fi] <= h_due_r;
        f_cnt_r     <= f_cnt_r + FC'(1);
      end
      if (cmd.emit_head) begin
        out_done_id    <= f_id_r[0];
        out_done_value <= f_val_r[0];
        for (int k = 0; k + 1 < FLIGHT_DEPTH; k++) begin
          f_id_r[k]  <= f_id_r[k+1];
          f_val_r[k] <= f_val_r[k+1];
          f_due_r[k] <= f_due_r[k+1];
        end
        f_cnt_r   <= f_cnt_r - FC'(1);
        emitted_r <= emitted_r + 5'd1;
      end
      // Search and removal: once matched, entries above shift down one a cycle.
      if (cmd.f_step) begin
        if (rem_r && 32'(idx_r) + 1 < 32'(f_cnt_r)) begin
          f_id_r[fi]  <= f_id_r[FA'(idx_r + SW'(1))];
          f_val_r[fi] <= f_val_r[FA'(idx_r + SW'(1))];
          f_due_r[fi] <= f_due_r[FA'(idx_r + SW'(1))];
        end
        if (!rem_r && stat.f_match) idx_r <= idx_r;
        else idx_r <= idx_r + SW'(1);
        if (rem_r && 32'(idx_r) + 1 >= 32'(f_cnt_r)) begin
          f_cnt_r <= f_cnt_r - FC'(1);
          rem_r   <= 1'b0;
        end else if (rem_r || stat.f_match) begin
          rem_r <= 1'b1;
        end
      end
      if (cmd.r_step) begin
        if (rem_r && 32'(idx_r) + 1 < 32'(r_cnt_r)) begin
          r_id_r[ri]  <= r_id_r[RA'(idx_r + SW'(1))];
          r_val_r[ri] <= r_val_r[RA'(idx_r + SW'(1))];
          r_lat_r[ri] <= r_lat_r[RA'(idx_r + SW'(1))];
        end
        if (!rem_r && stat.r_match) idx_r <= idx_r;
        else idx_r <= idx_r + SW'(1);
        if (rem_r && 32'(idx_r) + 1 >= 32'(r_cnt_r)) begin
          r_cnt_r <= r_cnt_r - RC'(1);
          rem_r   <= 1'b0;
        end else if (rem_r || stat.r_match) begin
          rem_r <= 1'b1;
        end
      end
      if (cmd.tick_done) cyc_r <= cyc_r + CYCLE_W'(1);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    32'(f_cnt_r) <= FLIGHT_DEPTH)
    else $error("flight count above depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(r_cnt_r) <= READY_DEPTH)
    else $error("ready count above depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_head |-> $past(1'b1) && f_cnt_r != '0)
    else $error("emit from empty flight list");

endmodule
`default_nettype wire

// File: rtl/locq_ctrl.sv
// Controller state machine of the completion queue: sequences push, tick and
// discard over the datapath. Depends on locq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module locq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [1:0]      in_opcode,
  input  wire locq_pkg::stat_t stat,
  output locq_pkg::cmd_t       cmd,
  output logic                 busy
);
  import locq_pkg::*;

  state_t state_r, state_nxt;
  opcode_t op_r, op_nxt;
  logic hold_r, hold_nxt;   // set while an emitted result waits for its last flag, or once a discard has matched

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_NONE;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    hold_nxt  = hold_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          op_nxt    = opcode_t'(in_opcode);
          hold_nxt  = 1'b0;
          unique case (opcode_t'(in_opcode))
            OP_PUSH:    state_nxt = ST_FINISH;
            OP_TICK:    state_nxt = ST_START;
            OP_DISCARD: state_nxt = ST_SEARCH_F;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_START: begin
        if (stat.width_left && !stat.ready_empty && stat.flight_room) begin
          cmd.ins_load = 1'b1;
          state_nxt    = ST_INSERT;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_INSERT: begin
        if (stat.ins_done) begin
          cmd.ins_place = 1'b1;
          state_nxt     = ST_START;
        end else begin
          cmd.ins_step = 1'b1;
        end
      end
      ST_DRAIN: begin
        // A completed result is registered; its last flag is
        // known only when the next head is examined.
        if (hold_r) begin
          cmd.out_valid = 1'b1;
          cmd.out_kind  = KIND_DONE;
        end
        if (stat.head_due && stat.emit_left) begin
          cmd.emit_head = 1'b1;
          hold_nxt      = 1'b1;
        end else begin
          cmd.out_last  = hold_r;
          cmd.tick_done = 1'b1;
          hold_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SEARCH_F: begin
        if (stat.removing || stat.f_match) begin
          cmd.f_step = 1'b1;
        end else if (stat.f_end) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SEARCH_R;
        end else begin
          cmd.f_step = 1'b1;
        end
        if (stat.removing && !stat.f_match && hold_r) begin
          hold_nxt = hold_r;
        end
        if (stat.removing || stat.f_match) hold_nxt = 1'b1;
        if (hold_r && !stat.removing && !stat.f_match) begin
          // removal finished
          cmd.out_valid = 1'b1;
          cmd.out_kind  = KIND_DISCARDED;
          cmd.out_last  = 1'b1;
          cmd.f_step    = 1'b0;
          cmd.scan_clr  = 1'b0;
          hold_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SEARCH_R: begin
        if (stat.removing || stat.r_match) begin
          cmd.r_step = 1'b1;
          hold_nxt   = 1'b1;
        end else if (hold_r) begin
          cmd.out_valid = 1'b1;
          cmd.out_kind  = KIND_DISCARDED;
          cmd.out_last  = 1'b1;
          hold_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (stat.r_end) begin
          cmd.out_valid = 1'b1;
          cmd.out_kind  = KIND_NOT_FOUND;
          cmd.out_last  = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.r_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat.ready_full) begin
          cmd.out_valid = 1'b1;
          cmd.out_kind  = KIND_FULL;
          cmd.out_last  = 1'b1;
        end else begin
          cmd.push = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_valid |-> busy)
    else $error("result outside an operation");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_last |-> cmd.out_valid)
    else $error("last flag without result");
  // The unused opcode is taken and dropped without leaving idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start && opcode_t'(in_opcode) != OP_NONE) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule
`default_nettype wire
